@@ src/c2dsz_pkg.sv @@
// ----------------------------------------------------------------------------
// c2dsz_pkg
// Shared sizes, codes, types and helpers for the same-size 2D convolution.
// ----------------------------------------------------------------------------
package c2dsz_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int MAX_SIDE = 15;

	// fixed field widths
	localparam int DIM_W     = 11;
	localparam int SIDE_W    = 4;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int DATA_W    = 16;
	localparam int CIDX_W    = 8;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = 40;

	// storage geometry
	localparam int KERNEL_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int KERNEL_AW    = $clog2(KERNEL_DEPTH);
	localparam int LINE_DEPTH   = MAX_SIDE * (MAX_COLS + 1);
	localparam int LINE_AW      = $clog2(LINE_DEPTH);

	// position and coordinate widths
	localparam int TOTAL_W = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int ROW_W   = $clog2(MAX_ROWS + 1);
	localparam int COL_W   = $clog2(MAX_COLS + 1);
	localparam int HALF_W  = $clog2((MAX_SIDE + 1) / 2 + 1);
	localparam int IDX_W   = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;

	// beat kinds (tuser)
	localparam logic [OP_W-1:0] OP_COEF  = 2'd0;
	localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd2;

	// per-tap control travelling with the memory read data
	typedef struct packed {
		logic valid;
		logic ok;
		logic last;
	} mac_ctl_t;

	// a + b modulo LINE_DEPTH, both operands already below LINE_DEPTH
	function automatic logic [LINE_AW-1:0] line_wrap_add(
		input logic [LINE_AW-1:0] a,
		input logic [LINE_AW-1:0] b
	);
		logic [LINE_AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (LINE_AW + 1)'(LINE_DEPTH)) begin
			s = s - (LINE_AW + 1)'(LINE_DEPTH);
		end
		return s[LINE_AW-1:0];
	endfunction

endpackage

@@ src/c2dsz_mac.sv @@
// ----------------------------------------------------------------------------
// c2dsz_mac
// Shared 16x16 signed multiply-accumulate; one tap per cycle, 40-bit sum.
// ----------------------------------------------------------------------------
module c2dsz_mac
	import c2dsz_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  mac_ctl_t                 ctl_s1,
	input  logic signed [DATA_W-1:0] pixel_s1,
	input  logic signed [DATA_W-1:0] coef_s1,
	output logic signed [SUM_W-1:0]  acc,
	output logic                     done
);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     done_q;

	// padding taps contribute zero
	always_ff @(posedge clk) begin
		if (ctl_s1.ok) begin
			prod_s2 <= pixel_s1 * coef_s1;
		end else begin
			prod_s2 <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + {{(SUM_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= ctl_s1.valid;
			last_s2  <= ctl_s1.valid & ctl_s1.last;
			done_q   <= valid_s2 & last_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

@@ src/conv2d_same_zero_pad.sv @@
// ----------------------------------------------------------------------------
// conv2d_same_zero_pad
// Same-size 2D convolution, odd square kernel, zero padding, streaming I/O.
// ----------------------------------------------------------------------------
// Beats on the slave side carry a kind in tuser: coefficient load, pixel (raster
// order) or flush tick. Coefficient loads and beats that produce no output leave
// the input side ready for the next beat. A pixel or flush beat that completes a
// window holds the input side until its result is loaded into the output
// register. The window is walked one tap per cycle through a single shared
// 16x16 multiply-accumulate, which sets the rate. The memory read, product and
// accumulator registers follow, then the output register is loaded. A result
// still waiting in that register holds the input side until it is taken.
// Outputs appear half*cols + half pixels behind the input, so send flush ticks
// after the last pixel to drain the image; tlast marks the final output, after
// which a new image starts. Sums are exact signed Q18.22 in 40 bits. A write to
// a real register (rows, cols or side) restarts the current image (the kernel is
// kept) and the input side is held for one cycle after it, and after reset, while
// the derived geometry settles. The line and kernel stores are not cleared; load
// every coefficient of the kernel before streaming pixels.
// ----------------------------------------------------------------------------
module conv2d_same_zero_pad
	import c2dsz_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [39:0]          s_axis_tdata,   // coef_index[7:0], coef_value[23:8], pixel_value[39:24]
	input  logic [OP_W-1:0]      s_axis_tuser,   // opcode[1:0]
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [SUM_W-1:0]     m_axis_tdata,   // out_value[39:0]
	output logic                 m_axis_tlast,   // last_output
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	// ---------------- payload unpack ----------------
	logic [CIDX_W-1:0] coef_index;
	logic [DATA_W-1:0] coef_value;
	logic [DATA_W-1:0] pixel_value;

	assign coef_index  = s_axis_tdata[7:0];
	assign coef_value  = s_axis_tdata[23:8];
	assign pixel_value = s_axis_tdata[39:24];

	// ---------------- registers as written ----------------
	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  cols_q;
	logic [SIDE_W-1:0] side_q;
	logic              settle_q;   // holds input for one cycle after reset / real cfg write

	// ---------------- derived geometry ----------------
	// Clamped dimensions and everything the sequencer needs, registered.
	logic [DIM_W-1:0]    rows_c, cols_c;
	logic [SIDE_W-1:0]   side_c;
	logic [HALF_W-1:0]   half_c;
	logic [2*DIM_W-1:0]  area_c;
	logic [LINE_AW-1:0]  lag_c;
	logic [LINE_AW:0]    step_c;

	always_comb begin
		if (rows_q == '0) begin
			rows_c = DIM_W'(1);
		end else if (rows_q > DIM_W'(MAX_ROWS)) begin
			rows_c = DIM_W'(MAX_ROWS);
		end else begin
			rows_c = rows_q;
		end

		if (cols_q == '0) begin
			cols_c = DIM_W'(1);
		end else if (cols_q > DIM_W'(MAX_COLS)) begin
			cols_c = DIM_W'(MAX_COLS);
		end else begin
			cols_c = cols_q;
		end

		if (side_q == '0) begin
			side_c = SIDE_W'(1);
		end else if (side_q > SIDE_W'(MAX_SIDE)) begin
			side_c = SIDE_W'(MAX_SIDE);
		end else begin
			side_c = side_q;
		end
		// even sides drop to the next odd size
		if (!side_c[0]) begin
			side_c = side_c - SIDE_W'(1);
		end

		half_c = HALF_W'(side_c >> 1);
		area_c = {{DIM_W{1'b0}}, rows_c} * {{DIM_W{1'b0}}, cols_c};
		lag_c  = LINE_AW'(half_c) * LINE_AW'(cols_c) + LINE_AW'(half_c);

		// address step from the end of one window row to the start of the next
		step_c = (LINE_AW + 1)'(cols_c) + (LINE_AW + 1)'(LINE_DEPTH + 1)
			- (LINE_AW + 1)'(side_c);
		if (step_c >= (LINE_AW + 1)'(LINE_DEPTH)) begin
			step_c = step_c - (LINE_AW + 1)'(LINE_DEPTH);
		end
	end

	logic [DIM_W-1:0]   rows_e_q, cols_e_q;
	logic [SIDE_W-1:0]  side_e_q;
	logic [HALF_W-1:0]  half_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] lag_q;
	logic [LINE_AW-1:0] lag_comp_q;   // LINE_DEPTH - lag
	logic [LINE_AW-1:0] row_step_q;

	always_ff @(posedge clk) begin
		rows_e_q   <= rows_c;
		cols_e_q   <= cols_c;
		side_e_q   <= side_c;
		half_q     <= half_c;
		total_q    <= area_c[TOTAL_W-1:0];
		lag_q      <= TOTAL_W'(lag_c);
		lag_comp_q <= LINE_AW'(LINE_DEPTH) - lag_c;
		row_step_q <= step_c[LINE_AW-1:0];
	end

	// ---------------- sequencer state ----------------
	state_t               state_q;
	logic [TOTAL_W-1:0]   in_pos_q;     // items taken into the current image
	logic [TOTAL_W-1:0]   out_pos_q;    // outputs produced in the current image
	logic [LINE_AW-1:0]   in_addr_q;    // in_pos mod LINE_DEPTH
	logic [LINE_AW-1:0]   out_addr_q;   // out_pos mod LINE_DEPTH
	logic [ROW_W-1:0]     r_q;          // output row
	logic [COL_W-1:0]     c_q;          // output column

	// window walk
	logic [LINE_AW-1:0]      rd_addr_q;
	logic [KERNEL_AW-1:0]    kidx_q;
	logic [SIDE_W-1:0]       kr_q, kc_q;
	logic signed [IDX_W-1:0] ir_q, ic_q;

	mac_ctl_t ctl_s1;

	// output register
	logic               m_valid_q;
	logic [SUM_W-1:0]   m_data_q;
	logic               m_last_q;

	// ---------------- handshakes ----------------
	logic in_fire, cfg_fire, out_free;

	assign s_axis_tready = (state_q == ST_IDLE) && !settle_q && !cfg_valid;
	assign cfg_ready     = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// ---------------- beat decode ----------------
	logic is_pos_beat;   // pixel or flush: advances the input position
	logic emit;          // this beat completes an output window
	logic cfg_real;      // write hits one of the three registers

	assign is_pos_beat = (s_axis_tuser == OP_PIXEL) || (s_axis_tuser == OP_FLUSH);
	assign emit = is_pos_beat && ((in_pos_q + TOTAL_W'(1)) > lag_q) && (out_pos_q < total_q);
	assign cfg_real = (cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS)
		|| (cfg_index == CFG_SIDE);

	// ---------------- stores ----------------
	logic [DATA_W-1:0] lmem [LINE_DEPTH];
	logic [DATA_W-1:0] kmem [KERNEL_DEPTH];
	logic [DATA_W-1:0] line_rd_s1;
	logic [DATA_W-1:0] kern_rd_s1;
	logic              line_we, kern_we;
	logic [DATA_W-1:0] line_wdata;

	// past the end of the image the beat only moves the position
	assign line_we    = in_fire && is_pos_beat && (in_pos_q < total_q);
	assign line_wdata = (s_axis_tuser == OP_PIXEL) ? pixel_value : '0;
	assign kern_we    = in_fire && (s_axis_tuser == OP_COEF)
		&& (coef_index < CIDX_W'(KERNEL_DEPTH));

	always_ff @(posedge clk) begin
		if (line_we) begin
			lmem[in_addr_q] <= line_wdata;
		end
		line_rd_s1 <= lmem[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		if (kern_we) begin
			kmem[coef_index[KERNEL_AW-1:0]] <= coef_value;
		end
		kern_rd_s1 <= kmem[kidx_q];
	end

	// ---------------- shared MAC ----------------
	logic signed [SUM_W-1:0] acc;
	logic                    mac_done;
	logic                    mac_start;

	assign mac_start = in_fire && emit;

	c2dsz_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mac_start),
		.ctl_s1   (ctl_s1),
		.pixel_s1 (line_rd_s1),
		.coef_s1  (kern_rd_s1),
		.acc      (acc),
		.done     (mac_done)
	);

	// ---------------- tap bookkeeping ----------------
	logic [SIDE_W-1:0] side_m1;
	logic              tap_ok;
	logic              row_end, win_end;
	logic              out_last;

	assign side_m1 = side_e_q - SIDE_W'(1);
	assign tap_ok  = (ir_q >= 0) && (ir_q < $signed(IDX_W'(rows_e_q)))
		&& (ic_q >= 0) && (ic_q < $signed(IDX_W'(cols_e_q)));
	assign row_end  = (kc_q == side_m1);
	assign win_end  = row_end && (kr_q == side_m1);
	assign out_last = ((out_pos_q + TOTAL_W'(1)) == total_q);

	// window walk registers: payload, no reset
	always_ff @(posedge clk) begin
		if (mac_start) begin
			rd_addr_q <= line_wrap_add(out_addr_q, lag_comp_q);
			kidx_q    <= '0;
			kr_q      <= '0;
			kc_q      <= '0;
			ir_q      <= $signed(IDX_W'(r_q)) - $signed(IDX_W'(half_q));
			ic_q      <= $signed(IDX_W'(c_q)) - $signed(IDX_W'(half_q));
		end else if (state_q == ST_MAC) begin
			kidx_q <= kidx_q + KERNEL_AW'(1);
			if (row_end) begin
				rd_addr_q <= line_wrap_add(rd_addr_q, row_step_q);
				kc_q      <= '0;
				kr_q      <= kr_q + SIDE_W'(1);
				ir_q      <= ir_q + IDX_W'(1);
				ic_q      <= $signed(IDX_W'(c_q)) - $signed(IDX_W'(half_q));
			end else begin
				rd_addr_q <= line_wrap_add(rd_addr_q, LINE_AW'(1));
				kc_q      <= kc_q + SIDE_W'(1);
				ic_q      <= ic_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= acc;
			m_last_q <= out_last;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rows_q     <= DIM_W'(1);
			cols_q     <= DIM_W'(1);
			side_q     <= SIDE_W'(3);
			settle_q   <= 1'b1;
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			in_addr_q  <= '0;
			out_addr_q <= '0;
			r_q        <= '0;
			c_q        <= '0;
			ctl_s1     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			// any real register write holds the input while geometry settles
			settle_q <= cfg_fire && cfg_real;

			// tap control lines up with the registered memory reads
			ctl_s1.valid <= (state_q == ST_MAC);
			ctl_s1.ok    <= (state_q == ST_MAC) && tap_ok;
			ctl_s1.last  <= (state_q == ST_MAC) && win_end;

			// output register: loaded from ST_OUT, cleared once taken
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						case (cfg_index)
							CFG_ROWS: rows_q <= cfg_data;
							CFG_COLS: cols_q <= cfg_data;
							CFG_SIDE: side_q <= cfg_data[SIDE_W-1:0];
							default: ;
						endcase
						// any real register restarts the image
						if (cfg_real) begin
							in_pos_q   <= '0;
							out_pos_q  <= '0;
							in_addr_q  <= '0;
							out_addr_q <= '0;
							r_q        <= '0;
							c_q        <= '0;
						end
					end else if (in_fire && is_pos_beat) begin
						in_pos_q  <= in_pos_q + TOTAL_W'(1);
						in_addr_q <= line_wrap_add(in_addr_q, LINE_AW'(1));
						if (emit) begin
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					if (win_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (out_last) begin
							// image complete: next beat starts a new one
							in_pos_q   <= '0;
							out_pos_q  <= '0;
							in_addr_q  <= '0;
							out_addr_q <= '0;
							r_q        <= '0;
							c_q        <= '0;
						end else begin
							out_pos_q  <= out_pos_q + TOTAL_W'(1);
							out_addr_q <= line_wrap_add(out_addr_q, LINE_AW'(1));
							if (COL_W'(c_q + COL_W'(1)) == COL_W'(cols_e_q)) begin
								c_q <= '0;
								r_q <= r_q + ROW_W'(1);
							end else begin
								c_q <= c_q + COL_W'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

@@ src/c2dsz_checker.sv @@
// ----------------------------------------------------------------------------
// c2dsz_checker
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module c2dsz_checker
	import c2dsz_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [OP_W-1:0]      s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [SUM_W-1:0]     m_axis_tdata,
	input logic                 m_axis_tlast,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// never a register write and an input beat at the same edge
	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !(s_axis_tvalid && s_axis_tready))
		else $error("register write and input beat together");

	// geometry settles for a cycle after a write to a real register
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready
			&& (cfg_index == CFG_ROWS || cfg_index == CFG_COLS || cfg_index == CFG_SIDE)
			|=> !s_axis_tready)
		else $error("input taken right after register write");

	// coefficient loads and ignored beats create no result
	a_coef_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready
			&& (s_axis_tuser == OP_COEF || s_axis_tuser == OP_NONE)
			|=> !$rose(m_axis_tvalid))
		else $error("result after a non-pixel beat");

endmodule

bind conv2d_same_zero_pad c2dsz_checker u_c2dsz_checker (.*);
